// ----- rtl/lsps_pkg.sv -----
`default_nettype none

package lsps_pkg;

    // frame geometry
    localparam int SENSOR_COUNT = 8;
    localparam int SAMPLE_BITS  = 12;
    localparam int POS_SHIFT    = $clog2(SENSOR_COUNT);
    localparam int WSUM_BITS    =
        SAMPLE_BITS + $clog2((SENSOR_COUNT * (SENSOR_COUNT - 1)) / 2 + 1);
    localparam int POS_BITS     = WSUM_BITS - POS_SHIFT;

    // register widths
    localparam int GOAL_BITS      = 14;
    localparam int GAIN_BITS      = 16;
    localparam int PULSE_BITS     = 12;
    localparam int RPULSE_BITS    = 13;
    localparam int SWING_BITS     = 10;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // arithmetic widths
    localparam int ERR_BITS   = 16;
    localparam int DIFF_BITS  = ERR_BITS + 1;
    localparam int FRAC_BITS  = 16;
    localparam int PROP_BITS  = GAIN_BITS + 1 + ERR_BITS;
    localparam int DERIV_BITS = GAIN_BITS + 1 + DIFF_BITS;
    localparam int ACC_BITS   = DERIV_BITS + 1;
    localparam int ADJ_BITS   = ACC_BITS - FRAC_BITS;
    localparam int SUM_BITS   = ADJ_BITS + 2;

    // register reset values
    localparam logic [GOAL_BITS-1:0]   GOAL_RESET   = 14'd2250;
    localparam logic [GAIN_BITS-1:0]   PROP_RESET   = 16'd1638;
    localparam logic [GAIN_BITS-1:0]   DERIV_RESET  = 16'd197;
    localparam logic [SAMPLE_BITS-1:0] THRESH_RESET = 12'd1000;
    localparam logic [SAMPLE_BITS-1:0] DARK_RESET   = 12'd2500;
    localparam logic [PULSE_BITS-1:0]  LBASE_RESET  = 12'd1520;
    localparam logic [PULSE_BITS-1:0]  RBASE_RESET  = 12'd1460;
    localparam logic [SWING_BITS-1:0]  SWING_RESET  = 10'd30;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GOAL_POSITION    = 3'd0,
        REG_PROP_GAIN        = 3'd1,
        REG_DERIV_GAIN       = 3'd2,
        REG_DARK_THRESHOLD   = 3'd3,
        REG_DARK_VALUE       = 3'd4,
        REG_LEFT_BASE_PULSE  = 3'd5,
        REG_RIGHT_BASE_PULSE = 3'd6,
        REG_PULSE_SWING      = 3'd7
    } cfg_index_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [SENSOR_COUNT-1:0] frame_t;

    typedef struct packed {
        logic [GOAL_BITS-1:0]   goal_position;
        logic [GAIN_BITS-1:0]   prop_gain;
        logic [GAIN_BITS-1:0]   deriv_gain;
        logic [SAMPLE_BITS-1:0] dark_threshold;
        logic [SAMPLE_BITS-1:0] dark_value;
        logic [PULSE_BITS-1:0]  left_base_pulse;
        logic [PULSE_BITS-1:0]  right_base_pulse;
        logic [SWING_BITS-1:0]  pulse_swing;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_BITS-1:0]  err;
        logic signed [DIFF_BITS-1:0] diff;
        logic                        dark;
    } pos_stage_t;

    typedef struct packed {
        logic signed [PROP_BITS-1:0]  prop;
        logic signed [DERIV_BITS-1:0] deriv;
        logic                         dark;
    } prod_stage_t;

    typedef struct packed {
        logic [PULSE_BITS-1:0]  left_pulse;
        logic [RPULSE_BITS-1:0] right_pulse;
        logic                   at_crossing;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/lsps_if.sv -----
`default_nettype none

// sensor frame channel
interface lsps_frame_if;
    logic                             valid;
    logic                             ready;
    logic [lsps_pkg::SAMPLE_BITS-1:0] sensor_0;
    logic [lsps_pkg::SAMPLE_BITS-1:0] sensor_1;
    logic [lsps_pkg::SAMPLE_BITS-1:0] sensor_2;
    logic [lsps_pkg::SAMPLE_BITS-1:0] sensor_3;
    logic [lsps_pkg::SAMPLE_BITS-1:0] sensor_4;
    logic [lsps_pkg::SAMPLE_BITS-1:0] sensor_5;
    logic [lsps_pkg::SAMPLE_BITS-1:0] sensor_6;
    logic [lsps_pkg::SAMPLE_BITS-1:0] sensor_7;

    modport source (
        output valid, sensor_0, sensor_1, sensor_2, sensor_3,
               sensor_4, sensor_5, sensor_6, sensor_7,
        input  ready
    );
    modport sink (
        input  valid, sensor_0, sensor_1, sensor_2, sensor_3,
               sensor_4, sensor_5, sensor_6, sensor_7,
        output ready
    );
endinterface

// wheel pulse channel
interface lsps_pulse_if;
    logic                             valid;
    logic                             ready;
    logic [lsps_pkg::PULSE_BITS-1:0]  left_pulse;
    logic [lsps_pkg::RPULSE_BITS-1:0] right_pulse;
    logic                             at_crossing;

    modport source (
        output valid, left_pulse, right_pulse, at_crossing,
        input  ready
    );
    modport sink (
        input  valid, left_pulse, right_pulse, at_crossing,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/lsps_cfg_regs.sv -----
`default_nettype none

module lsps_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [lsps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [lsps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output lsps_pkg::cfg_t                            cfg
);

    lsps_pkg::cfg_t cfg_reg;
    lsps_pkg::cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (lsps_pkg::cfg_index_t'(cfg_index))
                lsps_pkg::REG_GOAL_POSITION:
                    cfg_next.goal_position = cfg_data[lsps_pkg::GOAL_BITS-1:0];
                lsps_pkg::REG_PROP_GAIN:
                    cfg_next.prop_gain = cfg_data[lsps_pkg::GAIN_BITS-1:0];
                lsps_pkg::REG_DERIV_GAIN:
                    cfg_next.deriv_gain = cfg_data[lsps_pkg::GAIN_BITS-1:0];
                lsps_pkg::REG_DARK_THRESHOLD:
                    cfg_next.dark_threshold = cfg_data[lsps_pkg::SAMPLE_BITS-1:0];
                lsps_pkg::REG_DARK_VALUE:
                    cfg_next.dark_value = cfg_data[lsps_pkg::SAMPLE_BITS-1:0];
                lsps_pkg::REG_LEFT_BASE_PULSE:
                    cfg_next.left_base_pulse = cfg_data[lsps_pkg::PULSE_BITS-1:0];
                lsps_pkg::REG_RIGHT_BASE_PULSE:
                    cfg_next.right_base_pulse = cfg_data[lsps_pkg::PULSE_BITS-1:0];
                lsps_pkg::REG_PULSE_SWING:
                    cfg_next.pulse_swing = cfg_data[lsps_pkg::SWING_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.goal_position    <= lsps_pkg::GOAL_RESET;
            cfg_reg.prop_gain        <= lsps_pkg::PROP_RESET;
            cfg_reg.deriv_gain       <= lsps_pkg::DERIV_RESET;
            cfg_reg.dark_threshold   <= lsps_pkg::THRESH_RESET;
            cfg_reg.dark_value       <= lsps_pkg::DARK_RESET;
            cfg_reg.left_base_pulse  <= lsps_pkg::LBASE_RESET;
            cfg_reg.right_base_pulse <= lsps_pkg::RBASE_RESET;
            cfg_reg.pulse_swing      <= lsps_pkg::SWING_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/lsps_position.sv -----
`default_nettype none

module lsps_position (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic           in_valid,
    input  wire lsps_pkg::frame_t frame,
    input  wire lsps_pkg::cfg_t cfg,
    output logic                out_valid,
    output lsps_pkg::pos_stage_t stage
);

    lsps_pkg::frame_t                        frame_reg;
    logic                                    a_valid_reg;
    lsps_pkg::pos_stage_t                    stage_reg;
    lsps_pkg::pos_stage_t                    stage_next;
    logic                                    b_valid_reg;
    logic signed [lsps_pkg::ERR_BITS-1:0]    prev_err_reg;
    logic signed [lsps_pkg::ERR_BITS-1:0]    prev_err_next;

    lsps_pkg::frame_t                        subst;
    logic [lsps_pkg::WSUM_BITS-1:0]          weighted;
    logic [lsps_pkg::POS_BITS-1:0]           position;
    logic                                    all_dark;

    // input register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            frame_reg <= frame;
        end
    end

    // dark substitution and index-weighted sum
    always_comb
    begin
        weighted = '0;
        all_dark = 1'b1;
        for (int i = 0; i < lsps_pkg::SENSOR_COUNT; i++)
        begin
            subst[i] = (frame_reg[i] > cfg.dark_threshold) ? cfg.dark_value : frame_reg[i];
            if (subst[i] != cfg.dark_value)
            begin
                all_dark = 1'b0;
            end
            weighted = weighted + lsps_pkg::WSUM_BITS'(subst[i])
                                * lsps_pkg::WSUM_BITS'(i);
        end
    end

    // position is the weighted sum over the sensor count
    assign position = weighted[lsps_pkg::WSUM_BITS-1:lsps_pkg::POS_SHIFT];

    // error against the goal and its change since the last frame
    always_comb
    begin
        stage_next.err  = $signed(lsps_pkg::ERR_BITS'(cfg.goal_position))
                        - $signed(lsps_pkg::ERR_BITS'(position));
        stage_next.diff = $signed({stage_next.err[lsps_pkg::ERR_BITS-1], stage_next.err})
                        - $signed({prev_err_reg[lsps_pkg::ERR_BITS-1], prev_err_reg});
        stage_next.dark = all_dark;
        prev_err_next   = (advance && a_valid_reg) ? stage_next.err : prev_err_reg;
    end

    // error stage payload
    always_ff @(posedge clk)
    begin
        if (advance && a_valid_reg)
        begin
            stage_reg <= stage_next;
        end
    end

    // stage valids and last error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            prev_err_reg <= '0;
        end
        else
        begin
            prev_err_reg <= prev_err_next;
            if (advance)
            begin
                a_valid_reg <= in_valid;
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    assign out_valid = b_valid_reg;
    assign stage     = stage_reg;

endmodule

`default_nettype wire

// ----- rtl/lsps_pd_mult.sv -----
`default_nettype none

module lsps_pd_mult (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic                 in_valid,
    input  wire lsps_pkg::pos_stage_t stage_in,
    input  wire lsps_pkg::cfg_t       cfg,
    output logic                      out_valid,
    output lsps_pkg::prod_stage_t     stage_out
);

    lsps_pkg::prod_stage_t prod_reg;
    lsps_pkg::prod_stage_t prod_next;
    logic                  valid_reg;

    // proportional and derivative products, gains are unsigned q0.16
    always_comb
    begin
        prod_next.prop  = lsps_pkg::PROP_BITS'($signed({1'b0, cfg.prop_gain}))
                        * lsps_pkg::PROP_BITS'(stage_in.err);
        prod_next.deriv = lsps_pkg::DERIV_BITS'($signed({1'b0, cfg.deriv_gain}))
                        * lsps_pkg::DERIV_BITS'(stage_in.diff);
        prod_next.dark  = stage_in.dark;
    end

    // product stage payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    // product stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign stage_out = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/lsps_steer_out.sv -----
`default_nettype none

module lsps_steer_out (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire logic                  in_valid,
    input  wire lsps_pkg::prod_stage_t stage_in,
    input  wire lsps_pkg::cfg_t        cfg,
    output logic                       out_valid,
    output lsps_pkg::result_t          result
);

    localparam int SB = lsps_pkg::SUM_BITS;

    logic signed [lsps_pkg::ACC_BITS-1:0] acc;
    logic signed [lsps_pkg::ADJ_BITS-1:0] adj_floor;
    logic signed [lsps_pkg::ADJ_BITS-1:0] adj;
    logic signed [SB-1:0]                 lb_s;
    logic signed [SB-1:0]                 rb_s;
    logic signed [SB-1:0]                 llo;
    logic signed [SB-1:0]                 rhi;
    logic signed [SB-1:0]                 left_sum;
    logic signed [SB-1:0]                 right_sum;
    logic signed [SB-1:0]                 left_clamped;
    logic signed [SB-1:0]                 right_clamped;
    lsps_pkg::result_t                    res_reg;
    lsps_pkg::result_t                    res_next;
    logic                                 valid_reg;
    logic                                 valid_next;

    // pd sum, scaled down by 2^16 with truncation toward zero
    always_comb
    begin
        acc       = lsps_pkg::ACC_BITS'(stage_in.prop) + lsps_pkg::ACC_BITS'(stage_in.deriv);
        adj_floor = acc[lsps_pkg::ACC_BITS-1:lsps_pkg::FRAC_BITS];
        if (acc[lsps_pkg::ACC_BITS-1] && (acc[lsps_pkg::FRAC_BITS-1:0] != '0))
        begin
            adj = adj_floor + lsps_pkg::ADJ_BITS'(1);
        end
        else
        begin
            adj = adj_floor;
        end
    end

    // window limits, left window floored at zero
    always_comb
    begin
        lb_s = $signed(SB'(cfg.left_base_pulse));
        rb_s = $signed(SB'(cfg.right_base_pulse));
        llo  = lb_s - $signed(SB'(cfg.pulse_swing));
        if (llo < 0)
        begin
            llo = '0;
        end
        rhi       = rb_s + $signed(SB'(cfg.pulse_swing));
        left_sum  = lb_s + SB'(adj);
        right_sum = rb_s + SB'(adj);
    end

    // clamp both wheels, crossing takes the base pulses
    always_comb
    begin
        if (left_sum < llo)
        begin
            left_clamped = llo;
        end
        else if (left_sum > lb_s)
        begin
            left_clamped = lb_s;
        end
        else
        begin
            left_clamped = left_sum;
        end

        if (right_sum < rb_s)
        begin
            right_clamped = rb_s;
        end
        else if (right_sum > rhi)
        begin
            right_clamped = rhi;
        end
        else
        begin
            right_clamped = right_sum;
        end

        if (stage_in.dark)
        begin
            res_next.left_pulse  = cfg.left_base_pulse;
            res_next.right_pulse = lsps_pkg::RPULSE_BITS'(cfg.right_base_pulse);
        end
        else
        begin
            res_next.left_pulse  = left_clamped[lsps_pkg::PULSE_BITS-1:0];
            res_next.right_pulse = right_clamped[lsps_pkg::RPULSE_BITS-1:0];
        end
        res_next.at_crossing = stage_in.dark;
        valid_next = advance ? in_valid : valid_reg;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            res_reg <= res_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = res_reg;

endmodule

`default_nettype wire

// ----- rtl/line_sensor_pd_steering.sv -----
// throughput: one frame per cycle; four register stages (input, error, products,
// output) advance together and hold only while the output transfer is stalled
// reset: rst_n clears all stage valids and the last error, registers take defaults
`default_nettype none

module line_sensor_pd_steering (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    lsps_frame_if.sink                               sensors,
    lsps_pulse_if.source                             pulses,
    input  wire logic                                cfg_we,
    input  wire logic [lsps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [lsps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    lsps_pkg::cfg_t        cfg;
    lsps_pkg::frame_t      frame;
    lsps_pkg::pos_stage_t  pos_stage;
    lsps_pkg::prod_stage_t prod_stage;
    lsps_pkg::result_t     result;
    logic                  advance;
    logic                  pos_valid;
    logic                  prod_valid;
    logic                  out_valid;

    // whole pipeline moves unless a result waits on a stalled sink
    assign advance       = !out_valid || pulses.ready;
    assign sensors.ready = advance;

    // gather the frame
    assign frame[0] = sensors.sensor_0;
    assign frame[1] = sensors.sensor_1;
    assign frame[2] = sensors.sensor_2;
    assign frame[3] = sensors.sensor_3;
    assign frame[4] = sensors.sensor_4;
    assign frame[5] = sensors.sensor_5;
    assign frame[6] = sensors.sensor_6;
    assign frame[7] = sensors.sensor_7;

    lsps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsps_position u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (sensors.valid),
        .frame     (frame),
        .cfg       (cfg),
        .out_valid (pos_valid),
        .stage     (pos_stage)
    );

    lsps_pd_mult u_pd_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (pos_valid),
        .stage_in  (pos_stage),
        .cfg       (cfg),
        .out_valid (prod_valid),
        .stage_out (prod_stage)
    );

    lsps_steer_out u_steer_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (prod_valid),
        .stage_in  (prod_stage),
        .cfg       (cfg),
        .out_valid (out_valid),
        .result    (result)
    );

    // result channel
    assign pulses.valid       = out_valid;
    assign pulses.left_pulse  = result.left_pulse;
    assign pulses.right_pulse = result.right_pulse;
    assign pulses.at_crossing = result.at_crossing;

`ifndef SYNTHESIS
    // a crossing drives both wheels at their base pulses
    a_crossing_base: assert property (@(posedge clk) disable iff (!rst_n)
        pulses.valid && pulses.at_crossing |->
            pulses.left_pulse == cfg.left_base_pulse &&
            pulses.right_pulse == lsps_pkg::RPULSE_BITS'(cfg.right_base_pulse))
        else $error("crossing result not at base pulses");

    // steering results stay inside the right window
    a_right_window: assert property (@(posedge clk) disable iff (!rst_n)
        pulses.valid && !pulses.at_crossing |->
            pulses.right_pulse >= lsps_pkg::RPULSE_BITS'(cfg.right_base_pulse) &&
            pulses.right_pulse <= lsps_pkg::RPULSE_BITS'(cfg.right_base_pulse)
                                + lsps_pkg::RPULSE_BITS'(cfg.pulse_swing))
        else $error("right pulse outside its window");

    // steering results stay inside the left window
    a_left_window: assert property (@(posedge clk) disable iff (!rst_n)
        pulses.valid && !pulses.at_crossing |->
            pulses.left_pulse <= cfg.left_base_pulse &&
            (lsps_pkg::PULSE_BITS'(cfg.pulse_swing) > cfg.left_base_pulse ||
             pulses.left_pulse >= cfg.left_base_pulse
                                - lsps_pkg::PULSE_BITS'(cfg.pulse_swing)))
        else $error("left pulse outside its window");
`endif

endmodule

`default_nettype wire

// ----- verif/line_sensor_pd_steering_test.sv -----
`default_nettype none

module line_sensor_pd_steering_test;

    import lsps_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int PHASE_COUNT    = 7;
    localparam int FRAMES_PER_RUN = 64;

    localparam cfg_t DEFAULTS = '{
        goal_position:    GOAL_RESET,
        prop_gain:        PROP_RESET,
        deriv_gain:       DERIV_RESET,
        dark_threshold:   THRESH_RESET,
        dark_value:       DARK_RESET,
        left_base_pulse:  LBASE_RESET,
        right_base_pulse: RBASE_RESET,
        pulse_swing:      SWING_RESET
    };

    typedef enum {ROW_FRAME, ROW_SETTINGS} row_kind_t;

    typedef struct {
        row_kind_t kind;
        frame_t    frame;
        bit        typed;
        result_t   want;
        cfg_t      settings;
    } plan_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    lsps_frame_if frame_ch ();
    lsps_pulse_if pulse_ch ();

    // steering model state
    cfg_t                        model_cfg = DEFAULTS;
    logic signed [ERR_BITS-1:0]  last_error = '0;
    result_t                     expected_pulses[$];
    plan_row_t                   plan[$];
    int                          mismatches = 0;
    bit                          steady = 1'b0;

    line_sensor_pd_steering DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sensors   (frame_ch),
        .pulses    (pulse_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #10 clk = ~clk;

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("line_sensor_pd_steering: mismatch");
        $finish;
    end

    task automatic report_mismatch(string what, int got_v, int want_v);
        $display("%0t %s: got %0d, want %0d", $time, what, got_v, want_v);
        mismatches++;
    endtask

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // wheel pulses for one frame, advances the last error
    function automatic result_t steer_predict(frame_t f);
        result_t res;
        int      reading;
        int      weighted;
        int      position;
        bit      crossing;
        int      err_v;
        longint  acc;
        longint  adj;
        longint  lb;
        longint  rb;
        longint  left_lo;
        longint  left_v;
        longint  right_v;
        logic signed [ERR_BITS-1:0] err;
        weighted = 0;
        crossing = 1'b1;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            reading = int'(f[i]);
            if (reading > int'(model_cfg.dark_threshold))
                reading = int'(model_cfg.dark_value);
            if (reading != int'(model_cfg.dark_value))
                crossing = 1'b0;
            weighted += i * reading;
        end
        position = weighted / SENSOR_COUNT;
        err = ERR_BITS'(int'(model_cfg.goal_position) - position);
        err_v = int'(err);
        acc = longint'(model_cfg.prop_gain) * longint'(err_v)
            + longint'(model_cfg.deriv_gain) * (longint'(err_v) - longint'(last_error));
        adj = acc / 65536;
        last_error = err;
        lb = longint'(model_cfg.left_base_pulse);
        rb = longint'(model_cfg.right_base_pulse);
        if (crossing)
        begin
            left_v = lb;
            right_v = rb;
        end
        else
        begin
            left_lo = lb - longint'(model_cfg.pulse_swing);
            if (left_lo < 0)
                left_lo = 0;
            left_v = clamp_to(lb + adj, left_lo, lb);
            right_v = clamp_to(rb + adj, rb, rb + longint'(model_cfg.pulse_swing));
        end
        res.left_pulse = left_v[PULSE_BITS-1:0];
        res.right_pulse = right_v[RPULSE_BITS-1:0];
        res.at_crossing = crossing;
        return res;
    endfunction

    // frame builders
    function automatic frame_t uniform(sample_t v);
        frame_t f;
        for (int i = 0; i < SENSOR_COUNT; i++)
            f[i] = v;
        return f;
    endfunction

    function automatic frame_t single(int idx, sample_t v, sample_t rest);
        frame_t f;
        f = uniform(rest);
        f[idx] = v;
        return f;
    endfunction

    function automatic frame_t pair_frame(sample_t even, sample_t odd);
        frame_t f;
        for (int i = 0; i < SENSOR_COUNT; i++)
            f[i] = (i % 2 == 0) ? even : odd;
        return f;
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int     thr;
        int     mode;
        int     pick;
        thr = int'(model_cfg.dark_threshold);
        mode = $urandom_range(99, 0);
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            pick = $urandom_range(99, 0);
            if (mode < 10)
                // crossing: dark or above threshold everywhere
                f[i] = (thr < SAMPLE_MAX && pick < 50) ?
                       sample_t'($urandom_range(SAMPLE_MAX, thr + 1)) : model_cfg.dark_value;
            else if (mode < 20)
                f[i] = sample_t'($urandom);
            else if (pick < 50)
                f[i] = sample_t'($urandom_range(thr, 0));
            else if (pick < 75 && thr < SAMPLE_MAX)
                f[i] = sample_t'($urandom_range(SAMPLE_MAX, thr + 1));
            else if (pick < 85)
                f[i] = model_cfg.dark_value;
            else
                f[i] = sample_t'($urandom);
        end
        return f;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.goal_position    = GOAL_BITS'($urandom_range(14332, 0));
        c.prop_gain        = GAIN_BITS'($urandom);
        c.deriv_gain       = GAIN_BITS'($urandom);
        c.dark_threshold   = SAMPLE_BITS'($urandom);
        c.dark_value       = SAMPLE_BITS'($urandom);
        c.left_base_pulse  = PULSE_BITS'($urandom);
        c.right_base_pulse = PULSE_BITS'($urandom);
        c.pulse_swing      = SWING_BITS'($urandom);
        return c;
    endfunction

    // directed plan rows
    function automatic void add_frame(frame_t f);
        plan_row_t row;
        row.kind = ROW_FRAME;
        row.frame = f;
        row.typed = 1'b0;
        row.want = '0;
        row.settings = DEFAULTS;
        plan.push_back(row);
    endfunction

    function automatic void add_typed(frame_t f, int left_v, int right_v, bit crossing);
        plan_row_t row;
        row.kind = ROW_FRAME;
        row.frame = f;
        row.typed = 1'b1;
        row.want.left_pulse = PULSE_BITS'(left_v);
        row.want.right_pulse = RPULSE_BITS'(right_v);
        row.want.at_crossing = crossing;
        row.settings = DEFAULTS;
        plan.push_back(row);
    endfunction

    function automatic void add_settings(cfg_t c);
        plan_row_t row;
        row.kind = ROW_SETTINGS;
        row.frame = '0;
        row.typed = 1'b0;
        row.want = '0;
        row.settings = c;
        plan.push_back(row);
    endfunction

    // stall lengths: mostly short, now and then long
    function automatic int stall_len();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 80)
            return $urandom_range(3, 1);
        if (pick < 95)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // register writes, enable held high across the burst
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
    endtask

    task automatic apply_settings(cfg_t c);
        write_reg(REG_GOAL_POSITION, CFG_DATA_BITS'(c.goal_position));
        write_reg(REG_PROP_GAIN, c.prop_gain);
        write_reg(REG_DERIV_GAIN, c.deriv_gain);
        write_reg(REG_DARK_THRESHOLD, CFG_DATA_BITS'(c.dark_threshold));
        write_reg(REG_DARK_VALUE, CFG_DATA_BITS'(c.dark_value));
        write_reg(REG_LEFT_BASE_PULSE, CFG_DATA_BITS'(c.left_base_pulse));
        write_reg(REG_RIGHT_BASE_PULSE, CFG_DATA_BITS'(c.right_base_pulse));
        write_reg(REG_PULSE_SWING, CFG_DATA_BITS'(c.pulse_swing));
        cfg_we <= 1'b0;
        model_cfg = c;
    endtask

    // hold the sender off until the pipeline has drained
    task automatic wait_idle();
        frame_ch.valid <= 1'b0;
        while (expected_pulses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one frame transfer, expectation queued on acceptance
    task automatic send_frame(frame_t f, bit typed, result_t want);
        int      gap;
        result_t predicted;
        gap = 0;
        if (!steady && $urandom_range(99, 0) >= 60)
            gap = stall_len();
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.valid <= 1'b1;
        frame_ch.sensor_0 <= f[0];
        frame_ch.sensor_1 <= f[1];
        frame_ch.sensor_2 <= f[2];
        frame_ch.sensor_3 <= f[3];
        frame_ch.sensor_4 <= f[4];
        frame_ch.sensor_5 <= f[5];
        frame_ch.sensor_6 <= f[6];
        frame_ch.sensor_7 <= f[7];
        do
            @(posedge clk);
        while (!frame_ch.ready);
        predicted = steer_predict(f);
        expected_pulses.push_back(typed ? want : predicted);
    endtask

    // result side back-pressure
    initial
    begin
        int hold;
        pulse_ch.ready = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (steady)
                pulse_ch.ready <= 1'b1;
            else if (hold > 0)
                hold--;
            else if (pulse_ch.ready)
            begin
                pulse_ch.ready <= 1'b0;
                hold = stall_len() - 1;
            end
            else
            begin
                pulse_ch.ready <= 1'b1;
                hold = $urandom_range(12, 1);
            end
        end
    end

    // result checking against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pulse_ch.valid && pulse_ch.ready)
        begin
            if (expected_pulses.size() == 0)
                report_mismatch("result with no frame pending, left_pulse",
                                int'(pulse_ch.left_pulse), 0);
            else
            begin
                want = expected_pulses.pop_front();
                if (pulse_ch.left_pulse !== want.left_pulse)
                    report_mismatch("left_pulse", int'(pulse_ch.left_pulse),
                                    int'(want.left_pulse));
                if (pulse_ch.right_pulse !== want.right_pulse)
                    report_mismatch("right_pulse", int'(pulse_ch.right_pulse),
                                    int'(want.right_pulse));
                if (pulse_ch.at_crossing !== want.at_crossing)
                    report_mismatch("at_crossing", int'(pulse_ch.at_crossing),
                                    int'(want.at_crossing));
            end
        end
    end

    // stimulus
    initial
    begin
        cfg_t      c;
        plan_row_t row;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_GOAL_POSITION;
        cfg_data = '0;
        frame_ch.valid = 1'b0;
        frame_ch.sensor_0 = '0;
        frame_ch.sensor_1 = '0;
        frame_ch.sensor_2 = '0;
        frame_ch.sensor_3 = '0;
        frame_ch.sensor_4 = '0;
        frame_ch.sensor_5 = '0;
        frame_ch.sensor_6 = '0;
        frame_ch.sensor_7 = '0;

        // reset defaults: line far left saturates, all dark is a crossing
        add_typed(uniform(0), 1520, 1490, 1'b1 == 1'b0);
        add_typed(uniform(SAMPLE_MAX), 1520, 1460, 1'b1);
        add_frame(single(0, 1000, 0));
        add_frame(single(7, 1000, 0));
        add_frame(single(7, 1001, 0));
        add_frame(pair_frame(12'hAAA, 12'h555));
        add_frame(pair_frame(0, 1000));
        add_frame(single(4, SAMPLE_MAX, 500));
        add_frame(pair_frame(999, 2500));

        // dark value below threshold: raw readings equal to it still make a crossing
        c = DEFAULTS;
        c.dark_value = 700;
        add_settings(c);
        add_typed(uniform(700), 1520, 1460, 1'b1);
        add_typed(pair_frame(700, SAMPLE_MAX), 1520, 1460, 1'b1);
        add_frame(single(3, 699, 700));

        // swing wider than the left base: lower clamp stops at zero
        c.goal_position = 0;
        c.prop_gain = 16'hFFFF;
        c.left_base_pulse = 10;
        c.pulse_swing = 1023;
        add_settings(c);
        add_typed(single(7, 1000, 0), 0, 1460, 1'b0);
        add_typed(uniform(0), 10, 1462, 1'b0);
        add_frame(single(0, SAMPLE_MAX, 0));

        // upper extremes of every register but the dark value, goal at the largest position
        c = '{14332, 16'hFFFF, 16'hFFFF, SAMPLE_MAX, 700, SAMPLE_MAX, SAMPLE_MAX, 1023};
        add_settings(c);
        add_typed(uniform(0), 4095, 5118, 1'b0);
        add_typed(uniform(SAMPLE_MAX), 3072, 4095, 1'b0);

        // lower extremes: every reading collapses to a zero dark value
        c = '0;
        add_settings(c);
        add_typed(pair_frame(SAMPLE_MAX, 1), 0, 0, 1'b1);
        add_typed(uniform(0), 0, 0, 1'b1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apply_settings(DEFAULTS);

        // directed plan
        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_SETTINGS)
            begin
                wait_idle();
                apply_settings(row.settings);
            end
            else
                send_frame(row.frame, row.typed, row.want);
        end
        wait_idle();

        // random phases over several settings
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: c = DEFAULTS;
                2: c = '{14332, 16'hFFFF, 16'hFFFF, SAMPLE_MAX, SAMPLE_MAX,
                         SAMPLE_MAX, SAMPLE_MAX, 1023};
                4:
                begin
                    c = random_settings();
                    c.prop_gain = GAIN_BITS'($urandom_range(4000, 0));
                    c.deriv_gain = GAIN_BITS'($urandom_range(4000, 0));
                    c.left_base_pulse = PULSE_BITS'($urandom_range(200, 0));
                    c.pulse_swing = 1023;
                end
                5:
                begin
                    c = random_settings();
                    c.prop_gain = 0;
                    c.deriv_gain = 16'hFFFF;
                end
                default: c = random_settings();
            endcase
            steady = (phase == 1);
            apply_settings(c);
            for (int n = 0; n < FRAMES_PER_RUN; n++)
                send_frame(random_frame(), 1'b0, '0);
            wait_idle();
        end

        steady = 1'b0;
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("line_sensor_pd_steering: match");
        else
            $display("line_sensor_pd_steering: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ----- line_sensor_pd_steering.f -----
rtl/lsps_pkg.sv
rtl/lsps_if.sv
rtl/lsps_cfg_regs.sv
rtl/lsps_position.sv
rtl/lsps_pd_mult.sv
rtl/lsps_steer_out.sv
rtl/line_sensor_pd_steering.sv
verif/line_sensor_pd_steering_test.sv
